// File: hw/rtl/stack_sort_ascending_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stack sorter
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef STACK_SORT_ASCENDING_MACROS_SVH
`define STACK_SORT_ASCENDING_MACROS_SVH

// Same-cycle implication.
`define SSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// Stack sorter package
// Widths, depth and the structs passed between the sorter cells.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int DATA_W = 32;
    localparam int DEPTH  = 64;

    typedef logic signed [DATA_W-1:0] ssa_data_t;

    // What one cell shows its neighbours.
    typedef struct packed {
        logic      valid;
        logic      lt;     // incoming value sorts before this cell's value, or the cell is empty
        ssa_data_t value;
    } ssa_link_t;

    // Chain-wide control, the same for every cell.
    typedef struct packed {
        logic load;        // insert the broadcast value
        logic shift;       // move every value one cell towards the head
    } ssa_ctrl_t;

endpackage

// File: hw/rtl/ssa_cell.sv
// ----------------------------------------------------------------------------
// Stack sorter cell
// Holds one value of the sorted chain; inserts by ripple, drains by shift.
// ----------------------------------------------------------------------------
module ssa_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssa_pkg::ssa_ctrl_t ctrl,
    input  ssa_pkg::ssa_data_t din,
    input  ssa_pkg::ssa_link_t prev_link,
    input  ssa_pkg::ssa_link_t next_link,
    output ssa_pkg::ssa_link_t link
);

    logic               valid_reg;
    logic               valid_next;
    ssa_pkg::ssa_data_t value_reg;
    ssa_pkg::ssa_data_t value_next;
    logic               lt;

    // Empty cells accept anything; equal values stay behind older ones.
    assign lt = !valid_reg || (din < value_reg);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift) begin
            valid_next = next_link.valid;
            value_next = next_link.value;
        end else if (ctrl.load && lt) begin
            // take the neighbour's value if the new one lands further up
            valid_next = valid_reg | prev_link.valid;
            value_next = prev_link.lt ? prev_link.value : din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.lt    = lt;
    assign link.value = value_reg;

endmodule

// File: hw/rtl/stack_sort_ascending.sv
// ----------------------------------------------------------------------------
// Stack sorter, ascending
// Collects signed values and streams them back out smallest first.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one value per transaction in s_tdata, s_tlast closes
//   the set. One transaction is taken per cycle while loading; each value is
//   inserted in place in a row of DEPTH cells in the cycle it arrives.
//   Master channel m_*: after the closing transaction the stored values leave
//   smallest first, one per cycle while m_tready is high, the first in the
//   cycle after the closing transaction. m_tlast marks the largest value;
//   m_tuser[0] is high on every transaction of a run in which a value was
//   dropped because the row was full. Each output transaction shifts the
//   cell row one place towards the head.
//   s_tready is low while a run is being emitted. A stalled receiver simply
//   freezes the row: the head cell holds m_tdata until taken.
//   After the m_tlast transaction the row and the overflow flag are empty
//   again and input resumes.
//   Reset (aresetn low, synchronous) clears the cell valid bits, the emit
//   state and the overflow flag.
// ----------------------------------------------------------------------------
`include "stack_sort_ascending_macros.svh"

module stack_sort_ascending (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] overflow
);

    ssa_pkg::ssa_link_t link     [ssa_pkg::DEPTH];
    ssa_pkg::ssa_link_t prev_link[ssa_pkg::DEPTH];
    ssa_pkg::ssa_link_t next_link[ssa_pkg::DEPTH];
    ssa_pkg::ssa_ctrl_t ctrl;
    ssa_pkg::ssa_data_t din;

    logic emit_reg;
    logic emit_next;
    logic ovf_reg;
    logic ovf_next;
    logic full;
    logic s_fire;
    logic m_fire;

    logic [ssa_pkg::DEPTH-1:0] valid_vec;
    logic [ssa_pkg::DEPTH-1:0] order_bad;
    logic [ssa_pkg::DEPTH-1:0] gap_bad;

    assign din      = ssa_pkg::ssa_data_t'(s_tdata);
    assign full     = link[ssa_pkg::DEPTH-1].valid;
    assign s_tready = !emit_reg;
    assign s_fire   = s_tvalid && s_tready;

    // head cell feeds the master channel directly
    assign m_tvalid   = emit_reg && link[0].valid;
    assign m_tdata    = link[0].value;
    assign m_tlast    = !link[1].valid;
    assign m_tuser[0] = ovf_reg;
    assign m_fire     = m_tvalid && m_tready;

    // drop the value once the row is full
    assign ctrl.load  = s_fire && !full;
    assign ctrl.shift = m_fire;

    always_comb begin
        emit_next = emit_reg;
        ovf_next  = ovf_reg;
        if (s_fire && full) begin
            ovf_next = 1'b1;
        end
        if (s_fire && s_tlast) begin
            emit_next = 1'b1;
        end
        if (m_fire && m_tlast) begin
            // run complete: release input and clear the sticky flag
            emit_next = 1'b0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end else begin
            emit_reg <= emit_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Boundary cells: above the head sits a full cell the value never passes;
    // past the tail sits an empty one that drains in.
    genvar i;
    generate
        for (i = 0; i < ssa_pkg::DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_head
                assign prev_link[i] = '{valid: 1'b1, lt: 1'b0, value: '0};
            end else begin : g_mid
                assign prev_link[i] = link[i-1];
            end
            if (i == ssa_pkg::DEPTH - 1) begin : g_tail
                assign next_link[i] = '{valid: 1'b0, lt: 1'b1, value: '0};
            end else begin : g_body
                assign next_link[i] = link[i+1];
            end

            ssa_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .din       (din),
                .prev_link (prev_link[i]),
                .next_link (next_link[i]),
                .link      (link[i])
            );

            assign valid_vec[i] = link[i].valid;
            if (i == 0) begin : g_chk_head
                assign order_bad[i] = 1'b0;
                assign gap_bad[i]   = 1'b0;
            end else begin : g_chk
                assign order_bad[i] = link[i].valid && link[i-1].valid &&
                                      (link[i].value < link[i-1].value);
                assign gap_bad[i]   = link[i].valid && !link[i-1].valid;
            end
        end
    endgenerate

    // Checks on the row and the run control.
    `SSA_ASSERT_IMP(a_no_gap, aclk, aresetn, 1'b1, gap_bad == '0, "hole in cell row")
    `SSA_ASSERT_IMP(a_sorted, aclk, aresetn, 1'b1, order_bad == '0, "cell row out of order")
    `SSA_ASSERT_IMP(a_no_load_in_run, aclk, aresetn, m_tvalid, !s_tready, "input open during run")
    `SSA_ASSERT_NXT(a_run_end, aclk, aresetn, m_fire && m_tlast,
        !emit_reg && !ovf_reg && valid_vec == '0, "run did not clear")
    `SSA_ASSERT_NXT(a_ovf_set, aclk, aresetn, s_fire && full, ovf_reg, "overflow not flagged")

endmodule

// File: verif/tb_stack_sort_ascending.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the ascending stack sorter
// Streams sets of signed values into the sorter and checks every value it
// sends back against a behavioural copy kept alongside. A short table covers
// the extremes, duplicates and presorted orders. Random sets follow, mostly
// small, with some at or past the store depth to exercise dropping and the
// overflow flag. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_stack_sort_ascending;

    localparam int QUIET_LIMIT  = 2000;   // cycles without any transaction
    localparam int RANDOM_ITEMS = 450;
    localparam int DIRECTED_N   = 21;

    // One value leaving the sorter, as the checker sees it.
    typedef struct packed {
        ssa_pkg::ssa_data_t value;
        logic               last;
        logic               ovf;
    } sorted_beat_t;

    // One row of the directed table. Where typed is set the row closes a
    // single-value set from an empty store, so its result is written out.
    typedef struct packed {
        ssa_pkg::ssa_data_t value;
        logic               last;
        logic               typed;
        sorted_beat_t       beat;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] value
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] value_res
    logic        m_tlast;
    logic [0:0]  m_tuser;    // [0] overflow

    // Behavioural copy of the sorter: the values held so far in this set,
    // the sticky drop flag, and the values still owed by the sorter.
    ssa_pkg::ssa_data_t held_vals[$];
    logic               held_ovf;
    sorted_beat_t       due_results[$];

    // Typed expectation travelling alongside the current input transaction.
    logic         pin_on;
    sorted_beat_t pin_beat;

    bit           quiet_feed;
    int           mismatches;
    int           quiet_cycles;
    sorted_beat_t got;
    sorted_beat_t want;

    stim_row_t directed_rows [0:DIRECTED_N-1] = '{
        // single values from an empty store: the result is the value itself
        '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
        '{32'h7fff_ffff, 1'b1, 1'b1, '{32'h7fff_ffff, 1'b1, 1'b0}},
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{32'hffff_ffff, 1'b1, 1'b1, '{32'hffff_ffff, 1'b1, 1'b0}},
        '{32'h0000_0001, 1'b1, 1'b1, '{32'h0000_0001, 1'b1, 1'b0}},
        // mixed set with both extremes and repeated values
        '{32'h7fff_ffff, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'hffff_fffd, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'hffff_fffd, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b1, 1'b0, '0},
        // descending pair
        '{32'h0000_0002, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b1, 1'b0, '0},
        // already ascending across the sign boundary
        '{32'hffff_ffff, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, '0},
        '{32'h7fff_ffff, 1'b1, 1'b0, '0},
        // alternating bit patterns
        '{32'haaaa_aaaa, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 1'b1, 1'b0, '0}
    };

    stack_sort_ascending i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock, first rising edge at 5 ns.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Take one value into the held set; on the closing value sort the set
    // ascending and queue one result per held value. With keep low the state
    // still advances but the results are not queued (a typed row supplies
    // them instead).
    function automatic void load_value(input ssa_pkg::ssa_data_t v, input logic closes,
                                       input bit keep);
        ssa_pkg::ssa_data_t ordered[$];
        sorted_beat_t       beat;
        int                 pos;
        if (held_vals.size() < ssa_pkg::DEPTH) begin
            held_vals.push_back(v);
        end else begin
            held_ovf = 1'b1;
        end
        if (!closes) begin
            return;
        end
        // Insert each value after every value not greater, so equal values
        // sit next to each other.
        foreach (held_vals[i]) begin
            pos = 0;
            while (pos < ordered.size() && ordered[pos] <= held_vals[i]) begin
                pos++;
            end
            ordered.insert(pos, held_vals[i]);
        end
        if (keep) begin
            foreach (ordered[k]) begin
                beat.value = ordered[k];
                beat.last  = (k == ordered.size() - 1);
                beat.ovf   = held_ovf;
                due_results.push_back(beat);
            end
        end
        held_vals.delete();
        held_ovf = 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one; the sender skips it while feeding quietly.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Values weighted towards the extremes and a narrow band around zero,
    // where repeats are likely; the rest span all 32 bits.
    function automatic ssa_pkg::ssa_data_t pick_value();
        case ($urandom_range(0, 9))
            0:       return ssa_pkg::ssa_data_t'(32'h8000_0000 + $urandom_range(0, 3));
            1:       return ssa_pkg::ssa_data_t'(32'h7fff_ffff - $urandom_range(0, 3));
            2, 3:    return ssa_pkg::ssa_data_t'(int'($urandom_range(0, 16)) - 8);
            default: return ssa_pkg::ssa_data_t'($urandom());
        endcase
    endfunction

    // Present one input transaction and return at the edge that accepts it.
    // Valid is lowered only when a gap follows, so back-to-back values keep
    // it high.
    task automatic send_item(input ssa_pkg::ssa_data_t v, input logic closes,
                             input logic pinned, input sorted_beat_t beat);
        int unsigned gap;
        gap = quiet_feed ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= closes;
        pin_on   <= pinned;
        pin_beat <= beat;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // Monitor both channels on the same edge. Values read here are those
    // from before the edge, since every input is driven by nonblocking
    // assignment.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            load_value(s_tdata, s_tlast, !pin_on);
            if (pin_on && s_tlast) begin
                due_results.push_back(pin_beat);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tlast, m_tuser[0]};
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d last %b ovf %b",
                                          got.value, got.last, got.ovf));
            end else begin
                want = due_results.pop_front();
                if (got.value !== want.value) begin
                    report_mismatch($sformatf("value %0d, wanted %0d",
                                              got.value, want.value));
                end
                if (got.last !== want.last) begin
                    report_mismatch($sformatf("tlast %b on value %0d, wanted %b",
                                              got.last, want.value, want.last));
                end
                if (got.ovf !== want.ovf) begin
                    report_mismatch($sformatf("overflow %b on value %0d, wanted %b",
                                              got.ovf, want.value, want.ovf));
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too
    // long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_stack_sort_ascending: errors");
            $finish;
        end
    end

    // Receiver: alternate stretches of steady acceptance with bursts of
    // random stalls.
    initial begin
        int unsigned gap;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) < 3) begin
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                gap = pick_gap();
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Sender: reset, directed table, then random sets.
    initial begin
        int run_no;
        int run_len;
        int sent;
        int r;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tlast      <= 1'b0;
        pin_on       <= 1'b0;
        pin_beat     <= '0;
        quiet_feed   = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        held_ovf     = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].beat);
        end

        // Random sets. A few early runs are pinned to the store boundary:
        // exactly full, one past (the closing value itself is dropped) and
        // several past.
        run_no = 0;
        sent   = 0;
        while (sent < RANDOM_ITEMS) begin
            case (run_no)
                1: run_len = ssa_pkg::DEPTH;
                3: run_len = ssa_pkg::DEPTH + 1;
                5: run_len = ssa_pkg::DEPTH + 4;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 70) begin
                        run_len = $urandom_range(1, 8);
                    end else if (r < 85) begin
                        run_len = $urandom_range(9, ssa_pkg::DEPTH - 1);
                    end else begin
                        run_len = $urandom_range(ssa_pkg::DEPTH - 1, ssa_pkg::DEPTH + 4);
                    end
                end
            endcase
            quiet_feed = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < run_len; i++) begin
                send_item(pick_value(), i == run_len - 1, 1'b0, '0);
            end
            sent += run_len;
            run_no++;
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every owed value, then hold a little longer to
        // catch anything extra.
        do begin
            @(posedge aclk);
        end while (due_results.size() != 0);
        repeat (ssa_pkg::DEPTH + 16) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb_stack_sort_ascending: clean");
        end else begin
            $display("tb_stack_sort_ascending: errors");
        end
        $finish;
    end

endmodule
